/* rtl/core/rpg_pkg.sv */
package rpg_pkg;

    localparam int unsigned IDX_W      = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned COLOR_W    = 8;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // dividend is pixel_index * 256, one quotient bit per step
    localparam int unsigned DVD_W     = IDX_W + 8;
    localparam int unsigned DIV_STEPS = DVD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2);

    // register index, taken from paddr[2]
    localparam logic REG_EFFECT_LENGTH = 1'b0;

    localparam logic [7:0] SEG_1    = 8'd85;
    localparam logic [7:0] SEG_2    = 8'd170;
    localparam logic [7:0] FULL_LVL = 8'd255;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    function automatic t_rgb wheel(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] v;
        logic [9:0] v3;
        t_rgb       c;
        w = ~pos;
        if (w < SEG_1) begin
            v = w;
        end else if (w < SEG_2) begin
            v = w - SEG_1;
        end else begin
            v = w - SEG_2;
        end
        v3 = {2'b00, v} * 10'd3;
        if (w < SEG_1) begin
            c.red   = FULL_LVL - v3[7:0];
            c.green = '0;
            c.blue  = v3[7:0];
        end else if (w < SEG_2) begin
            c.red   = '0;
            c.green = v3[7:0];
            c.blue  = FULL_LVL - v3[7:0];
        end else begin
            c.red   = v3[7:0];
            c.green = FULL_LVL - v3[7:0];
            c.blue  = '0;
        end
        return c;
    endfunction

endpackage

/* rtl/core/rpg_div.sv */
module rpg_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpg_pkg::IDX_W-1:0]  i_pixel_index,
    input  logic [rpg_pkg::LEN_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [7:0]                 o_quo
);
    import rpg_pkg::*;

    logic                 r_run, n_run;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [LEN_W-1:0]     r_rem, n_rem;
    logic [DVD_W-1:0]     r_dvd, n_dvd;
    logic [7:0]           r_quo, n_quo;

    logic [LEN_W:0]       rem_sh;
    logic [LEN_W+1:0]     diff;
    logic                 qbit;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_divisor};
        qbit   = ~diff[LEN_W+1];
    end

    always_comb begin
        n_run  = r_run;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        if (i_start) begin
            n_run  = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = {i_pixel_index, 8'h00};
        end else if (r_run) begin
            n_rem = qbit ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
            n_quo = {r_quo[6:0], qbit};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/core/rainbow_pixel_generator.sv */
// accepted request: bit-serial divide, then wheel color into the output register
// requests stall until the last result is loaded; bit-serial divider (16 steps)
// a finished result waits in the output register while the next request is divided
// reset (i_rst_n low, synchronous): phase 0, effect_length 2, no result pending
module rainbow_pixel_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rpg_pkg::IDX_W-1:0]       i_pixel_index,
    input  logic                            i_new_frame,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rpg_pkg::COLOR_W-1:0]     o_red,
    output logic [rpg_pkg::COLOR_W-1:0]     o_green,
    output logic [rpg_pkg::COLOR_W-1:0]     o_blue,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rpg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rpg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import rpg_pkg::*;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [7:0]        r_phase, n_phase;
    logic              r_out_valid, n_out_valid;
    t_rgb              r_rgb, n_rgb;

    logic              in_acc;
    logic              slot_free;
    logic              load_out;
    logic              div_done;
    logic [7:0]        div_quo;
    logic [LEN_W-1:0]  divisor;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_EFFECT_LENGTH)
                    ? {(APB_DATA_W - LEN_W)'(0), r_len} : '0;

    // zero length divides by one
    assign divisor   = (r_len == '0) ? LEN_W'(1) : r_len;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign in_acc    = i_in_valid && !o_in_stall;

    rpg_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_acc),
        .i_pixel_index (i_pixel_index),
        .i_divisor     (divisor),
        .o_done        (div_done),
        .o_quo         (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_BUSY;
            end
            S_BUSY: begin
                if (div_done && slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_BUSY: load_out   = div_done && slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_len = r_len;
        if (cfg_wr && paddr[2] == REG_EFFECT_LENGTH) n_len = pwdata[LEN_W-1:0];
        n_phase = r_phase;
        if (in_acc && i_new_frame) n_phase = r_phase + 8'd1;
        n_rgb = r_rgb;
        if (load_out) n_rgb = wheel(div_quo + r_phase);
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_RESET;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_rgb <= n_rgb;
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_rgb.red;
    assign o_green     = r_rgb.green;
    assign o_blue      = r_rgb.blue;

endmodule

/* rtl/core/rpg_chk.sv */
module rpg_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic [rpg_pkg::COLOR_W-1:0]  o_red,
    input  logic [rpg_pkg::COLOR_W-1:0]  o_green,
    input  logic [rpg_pkg::COLOR_W-1:0]  o_blue
);
    import rpg_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue))
        else $error("stalled result changed");

    // one request in flight: the next is refused right after an accept
    a_busy_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request taken while divider busy");

    // divider needs all its steps before a new request
    a_busy_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##DIV_STEPS o_in_stall)
        else $error("request taken before division finished");

    // reset leaves no result pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind rainbow_pixel_generator rpg_chk u_rpg_chk (.*);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
    import rpg_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PIXELS_PER_BLOCK = 34;
    localparam logic [APB_ADDR_W-1:0] LEN_ADDR = {REG_EFFECT_LENGTH, 2'b00};

    typedef enum logic {
        ROW_PIXEL,
        ROW_SET_LEN
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [IDX_W-1:0]   pixel;
        logic               new_frame;
        logic [LEN_W-1:0]   length;
        logic               typed;
        t_rgb               color;
    } t_row;

    localparam int unsigned DIRECTED_ROWS = 23;

    // pixel rows leave length 0; set-length rows leave the pixel fields 0
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_PIXEL,   8'd0,   1'b0, 16'd0,     1'b1, {8'd255, 8'd0, 8'd0}},
        '{ROW_PIXEL,   8'd255, 1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd1,   1'b1, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd128, 1'b1, 16'd0,     1'b0, 24'd0},
        '{ROW_SET_LEN, 8'd0,   1'b0, 16'd256,   1'b0, 24'd0},
        // phase is 2 here, so these land on the segment edges 85, 86, 170, 171
        '{ROW_PIXEL,   8'd83,  1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd84,  1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd168, 1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd169, 1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd0,   1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd255, 1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_SET_LEN, 8'd0,   1'b0, 16'd1,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd255, 1'b1, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd0,   1'b0, 16'd0,     1'b0, 24'd0},
        // zero length divides as if it were one
        '{ROW_SET_LEN, 8'd0,   1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd255, 1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd7,   1'b1, 16'd0,     1'b0, 24'd0},
        '{ROW_SET_LEN, 8'd0,   1'b0, 16'd65535, 1'b0, 24'd0},
        '{ROW_PIXEL,   8'd255, 1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd255, 1'b1, 16'd0,     1'b0, 24'd0},
        '{ROW_SET_LEN, 8'd0,   1'b0, 16'd3,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd255, 1'b0, 16'd0,     1'b0, 24'd0},
        '{ROW_PIXEL,   8'd200, 1'b1, 16'd0,     1'b0, 24'd0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [IDX_W-1:0]       i_pixel_index = '0;
    logic                   i_new_frame = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [COLOR_W-1:0]     o_red;
    logic [COLOR_W-1:0]     o_green;
    logic [COLOR_W-1:0]     o_blue;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // predictor state
    logic [LEN_W-1:0]       active_length = LEN_RESET;
    logic [7:0]             hue_phase = '0;
    t_rgb                   expected_colors [$];

    int unsigned            err_count = 0;
    int unsigned            cycle_count = 0;
    int unsigned            send_idle_pct = 0;
    int unsigned            recv_idle_pct = 0;
    int unsigned            holds_asked = 0;
    int unsigned            holds_done = 0;
    int unsigned            hold_left = 0;

    rainbow_pixel_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_index (i_pixel_index),
        .i_new_frame   (i_new_frame),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // color of one pixel for a given phase and length
    function automatic t_rgb pixel_color(logic [IDX_W-1:0] idx, logic [7:0] phase,
                                         logic [LEN_W-1:0] len);
        int unsigned divisor;
        int unsigned pos;
        int unsigned w;
        t_rgb        c;
        divisor = (len == 0) ? 1 : int'(len);
        pos = ((int'(idx) * 256) / divisor + int'(phase)) % 256;
        w = int'(FULL_LVL) - pos;
        if (w < SEG_1) begin
            c.red   = FULL_LVL - 8'(3 * w);
            c.green = '0;
            c.blue  = 8'(3 * w);
        end else if (w < SEG_2) begin
            w = w - SEG_1;
            c.red   = '0;
            c.green = 8'(3 * w);
            c.blue  = FULL_LVL - 8'(3 * w);
        end else begin
            w = w - SEG_2;
            c.red   = 8'(3 * w);
            c.green = FULL_LVL - 8'(3 * w);
            c.blue  = '0;
        end
        return c;
    endfunction

    // offers one request; returns at the edge that accepts it
    task automatic send_pixel(logic [IDX_W-1:0] idx, logic nf, logic typed, t_rgb color);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_index <= idx;
        i_new_frame   <= nf;
        do @(posedge i_clk); while (o_in_stall);
        if (nf) begin
            hue_phase = hue_phase + 8'd1;
        end
        expected_colors.push_back(typed ? color : pixel_color(idx, hue_phase, active_length));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_colors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic read_length();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LEN_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {{(APB_DATA_W-LEN_W){1'b0}}, active_length}) begin
            flag_error($sformatf("effect_length readback: expected %0d, got %0d",
                                 active_length, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_length(logic [LEN_W-1:0] len);
        logic [APB_DATA_W-1:0] wdata;
        wdata = $urandom;
        wdata[LEN_W-1:0] = len;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEN_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        active_length = len;
        read_length();
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_colors.size() == 0) begin
                flag_error($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                     o_red, o_green, o_blue));
            end else begin
                want = expected_colors.pop_front();
                if (o_red !== want.red || o_green !== want.green || o_blue !== want.blue) begin
                    flag_error($sformatf("color mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                         want.red, want.green, want.blue,
                                         o_red, o_green, o_blue));
                end
            end
        end
    end

    // receiver: random stalls, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            holds_done  <= holds_done + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [LEN_W-1:0] next_len;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_length();

        send_idle_pct = 20;
        recv_idle_pct = 46;
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_SET_LEN) begin
                wait_drained();
                program_length(DIRECTED[r].length);
            end else begin
                send_pixel(DIRECTED[r].pixel, DIRECTED[r].new_frame,
                           DIRECTED[r].typed, DIRECTED[r].color);
            end
        end

        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                wait_drained();
                case ($urandom_range(7))
                    0: next_len = 16'd1;
                    1: next_len = 16'hFFFF;
                    2: next_len = 16'd0;
                    3: next_len = LEN_W'($urandom);
                    4: next_len = LEN_W'($urandom_range(16));
                    default: next_len = LEN_W'($urandom_range(1, 600));
                endcase
                program_length(next_len);
                // long output hold while requests keep coming, so the input backs up
                if (stage == 0 && blk == 1) begin
                    holds_asked++;
                end
                for (int n = 0; n < PIXELS_PER_BLOCK; n++) begin
                    send_pixel(IDX_W'($urandom_range(255)), $urandom_range(3) != 0,
                               1'b0, '0);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (expected_colors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_colors.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rpg_pkg.sv
rtl/core/rpg_div.sv
rtl/core/rainbow_pixel_generator.sv
rtl/core/rpg_chk.sv
sim/tb.sv
